// ===== src/lphi_pkg.sv =====
`default_nettype none
package lphi_pkg;
   localparam int SlotBits  = 8;
   localparam int RowBits   = 8;
   localparam int TableRows = 256;
   localparam int MaxProbes = 8;
   localparam int LimitBits = 4;
   localparam int CntBits   = 9;
   localparam int QueueBits = 1;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_NO_SLOT   = 2'd2;
   localparam logic [1:0] ST_ROWS_FULL = 2'd3;

   typedef struct packed {
      logic                 opcode;
      logic                 rows_full;
      logic [RowBits-1:0]   row;
      logic [LimitBits-1:0] limit;
      logic [31:0]          key_hash;
      logic [31:0]          key_value;
   } cmd_type;
endpackage
`default_nettype wire

// ===== src/lphi_front.sv =====
`default_nettype none
module lphi_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic                          req_opcode,
   input  wire logic [31:0]                   req_key_hash,
   input  wire logic [31:0]                   req_key_value,
   input  wire logic [31:0]                   req_payload_in,
   input  wire logic [lphi_pkg::LimitBits-1:0] limit,
   input  wire logic                          pop,
   output logic                               cmd_valid,
   output lphi_pkg::cmd_type                  cmd,
   output logic                               queue_full,
   input  wire logic [lphi_pkg::RowBits-1:0]  rd_row,
   output logic [31:0]                        rd_key,
   output logic [31:0]                        rd_payload
);
   logic [31:0] row_key_mem [lphi_pkg::TableRows];
   logic [31:0] row_payload_mem [lphi_pkg::TableRows];
   logic [lphi_pkg::CntBits-1:0] row_count_ff, row_count_in;
   lphi_pkg::cmd_type q_ff [2];
   logic [lphi_pkg::QueueBits-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [lphi_pkg::QueueBits:0] cnt_ff, cnt_in;
   lphi_pkg::cmd_type c;
   logic full_rows, do_write;

   assign full_rows = row_count_ff >= lphi_pkg::CntBits'(lphi_pkg::TableRows);
   assign do_write  = accept && req_opcode == lphi_pkg::OP_INSERT && !full_rows;

   always_comb begin
      c.opcode    = req_opcode;
      c.rows_full = full_rows;
      c.row       = row_count_ff[lphi_pkg::RowBits-1:0];
      c.limit     = (limit > lphi_pkg::LimitBits'(lphi_pkg::MaxProbes)) ?
                    lphi_pkg::LimitBits'(lphi_pkg::MaxProbes) : limit;
      c.key_hash  = req_key_hash;
      c.key_value = req_key_value;
      row_count_in = do_write ? row_count_ff + 1'b1 : row_count_ff;
      wp_in  = accept ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (accept ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         row_count_ff <= row_count_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) q_ff[wp_ff] <= c;
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         row_key_mem[row_count_ff[lphi_pkg::RowBits-1:0]]     <= req_key_value;
         row_payload_mem[row_count_ff[lphi_pkg::RowBits-1:0]] <= req_payload_in;
      end
      rd_key     <= row_key_mem[rd_row];
      rd_payload <= row_payload_mem[rd_row];
   end

   assign cmd_valid  = cnt_ff != '0;
   assign cmd        = q_ff[rp_ff];
   assign queue_full = cnt_ff[lphi_pkg::QueueBits];
endmodule
`default_nettype wire

// ===== src/lphi_back.sv =====
`default_nettype none
module lphi_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         cmd_valid,
   input  wire lphi_pkg::cmd_type            cmd,
   output logic                              pop,
   output logic                              idle,
   output logic [lphi_pkg::RowBits-1:0]      rd_row,
   input  wire logic [31:0]                  rd_key,
   input  wire logic [31:0]                  rd_payload,
   output logic                              rsp_strobe,
   output logic [1:0]                        rsp_status,
   output logic [7:0]                        rsp_row_number,
   output logic [31:0]                       rsp_payload_out
);
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_CHECK = 5'b00100,
      S_KEY   = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   logic [255:0] valid_ff;
   logic [31:0] hash_mem [256];
   logic [7:0]  row_mem [256];
   logic [31:0] s_hash;
   logic [7:0]  s_row;
   state_type state_ff, state_in;
   logic [lphi_pkg::SlotBits-1:0] slot_ff, slot_in;
   logic [lphi_pkg::LimitBits-1:0] left_ff, left_in;
   lphi_pkg::cmd_type cur_ff, cur_in;
   logic [1:0] st_ff, st_in;
   logic [7:0] row_ff, row_in;
   logic [31:0] pay_ff, pay_in;
   logic strobe_ff, strobe_in, claim;

   assign rd_row = s_row;

   always_comb begin
      state_in = state_ff; slot_in = slot_ff; left_in = left_ff; cur_in = cur_ff;
      st_in = st_ff; row_in = row_ff; pay_in = pay_ff; strobe_in = 1'b0;
      pop = 1'b0; claim = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               pop = 1'b1;
               cur_in = cmd;
               slot_in = cmd.key_hash[lphi_pkg::SlotBits-1:0];
               left_in = cmd.limit;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (cur_ff.opcode == lphi_pkg::OP_INSERT && cur_ff.rows_full) begin
               st_in = lphi_pkg::ST_ROWS_FULL; row_in = '0; pay_in = '0;
               state_in = S_DONE;
            end else if (left_ff == '0) begin
               pay_in = '0;
               if (cur_ff.opcode == lphi_pkg::OP_INSERT) begin
                  st_in = lphi_pkg::ST_NO_SLOT; row_in = cur_ff.row;
               end else begin
                  st_in = lphi_pkg::ST_NOT_FOUND; row_in = '0;
               end
               state_in = S_DONE;
            end else if (cur_ff.opcode == lphi_pkg::OP_INSERT) begin
               if (!valid_ff[slot_ff]) begin
                  claim = 1'b1;
                  st_in = lphi_pkg::ST_OK; row_in = cur_ff.row; pay_in = '0;
                  state_in = S_DONE;
               end else begin
                  slot_in = slot_ff + 1'b1; left_in = left_ff - 1'b1;
               end
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (valid_ff[slot_ff] && s_hash == cur_ff.key_hash) begin
               state_in = S_KEY;
            end else begin
               slot_in = slot_ff + 1'b1; left_in = left_ff - 1'b1;
               state_in = S_READ;
            end
         end
         S_KEY: begin
            if (rd_key == cur_ff.key_value) begin
               st_in = lphi_pkg::ST_OK; row_in = s_row; pay_in = rd_payload;
               state_in = S_DONE;
            end else begin
               slot_in = slot_ff + 1'b1; left_in = left_ff - 1'b1;
               state_in = S_READ;
            end
         end
         S_DONE: begin
            strobe_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         strobe_ff <= strobe_in;
         if (claim) valid_ff[slot_ff] <= 1'b1;
      end
      slot_ff <= slot_in; left_ff <= left_in; cur_ff <= cur_in;
      st_ff <= st_in; row_ff <= row_in; pay_ff <= pay_in;
   end

   always_ff @(posedge clock) begin
      if (claim) begin
         hash_mem[slot_ff] <= cur_ff.key_hash;
         row_mem[slot_ff]  <= cur_ff.row;
      end
      s_hash <= hash_mem[slot_ff];
      s_row  <= row_mem[slot_ff];
   end

   assign idle            = state_ff == S_IDLE && !cmd_valid;
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = st_ff;
   assign rsp_row_number  = row_ff;
   assign rsp_payload_out = pay_ff;
endmodule
`default_nettype wire

// ===== src/linear_probe_hash_index_top.sv =====
`default_nettype none
// Hash index over an append-only row store. A request is taken when start is
// high and busy low; its result appears for one cycle with rsp_strobe and
// cannot be held off. With the probe sequencer free, the request is worked in
// an entry step, one step per slot probed on inserts, and on lookups a slot
// memory read and a hash check per probed slot plus a row key read when the
// stored hash matches, up to probe_limit slots (at most 8), then a limit check
// and a result step. A two-entry queue lets the next request be taken while
// the probe sequencer works. probe_limit is written through csr_ only while
// idle and no request is being presented.
module linear_probe_hash_index_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_opcode,
   input  wire logic [31:0] req_key_hash,
   input  wire logic [31:0] req_key_value,
   input  wire logic [31:0] req_payload_in,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_row_number,
   output logic [31:0]      rsp_payload_out,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_probe_limit
);
   logic [lphi_pkg::LimitBits-1:0] limit_ff;
   logic accept, pop, cmd_valid, queue_full, idle;
   lphi_pkg::cmd_type cmd;
   logic [lphi_pkg::RowBits-1:0] rd_row;
   logic [31:0] rd_key, rd_payload;

   assign busy      = queue_full;
   assign accept    = start && !busy;
   assign csr_ready = idle && !start;

   always_ff @(posedge clock) begin
      if (reset) limit_ff <= lphi_pkg::LimitBits'(lphi_pkg::MaxProbes);
      else if (csr_valid && csr_ready) limit_ff <= csr_probe_limit;
   end

   lphi_front u_front (
      .clock, .reset, .accept, .req_opcode, .req_key_hash, .req_key_value,
      .req_payload_in, .limit(limit_ff), .pop, .cmd_valid, .cmd, .queue_full,
      .rd_row, .rd_key, .rd_payload
   );

   lphi_back u_back (
      .clock, .reset, .cmd_valid, .cmd, .pop, .idle, .rd_row, .rd_key, .rd_payload,
      .rsp_strobe, .rsp_status, .rsp_row_number, .rsp_payload_out
   );
endmodule
`default_nettype wire
